FILE: src/sro_pkg.sv
// Shared types and constants for the sequence reorder buffer.
// No dependencies; every other file imports this package.
package sro_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned SeqW         = 31;
  localparam int unsigned TagW         = 16;
  localparam int unsigned NumW         = 32;
  localparam int unsigned OccW         = 5;

  localparam logic signed [NumW-1:0] NoneNum = -32'sd1;

  typedef enum logic [1:0] {
    CMD_RECEIVE = 2'd0,
    CMD_POP     = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_NOT_READY = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_INSERT,
    S_WALK_RD,
    S_WALK,
    S_POP,
    S_HEAD
  } state_e;

  typedef struct packed {
    logic [SeqW-1:0] seq;
    logic [TagW-1:0] tag;
  } entry_t;

endpackage

FILE: src/sro_if.sv
// Valid/ready channel interfaces for the reorder buffer command and result beats.
// Depends on sro_pkg for field widths.
interface sro_in_if import sro_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             command;
  logic [SeqW-1:0]        seq_number;
  logic [TagW-1:0]        payload_tag;
  logic signed [NumW-1:0] last_processed;

  modport source (output valid, command, seq_number, payload_tag, last_processed,
                  input ready);
  modport sink   (input valid, command, seq_number, payload_tag, last_processed,
                  output ready);
endinterface

interface sro_out_if import sro_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic [SeqW-1:0]        out_seq;
  logic [TagW-1:0]        out_tag;
  logic signed [NumW-1:0] head_seq;
  logic signed [NumW-1:0] contiguous_seq;
  logic [OccW-1:0]        occupancy;

  modport source (output valid, status, out_seq, out_tag, head_seq, contiguous_seq,
                  occupancy, input ready);
  modport sink   (input valid, status, out_seq, out_tag, head_seq, contiguous_seq,
                  occupancy, output ready);
endinterface

FILE: src/sro_cmp.sv
// Shared comparator: unsigned sequence number against a signed 33-bit operand.
// Depends on sro_pkg for widths.
module sro_cmp import sro_pkg::*; (
  input  logic [SeqW-1:0]      a_i,
  input  logic signed [NumW:0] b_i,
  output logic                 gt_o,
  output logic                 eq_o
);

  logic signed [NumW:0] a_ext;

  // Zero-extend into the signed compare domain
  assign a_ext = $signed({2'b00, a_i});
  assign gt_o  = (a_ext > b_i);
  assign eq_o  = (a_ext == b_i);

endmodule

FILE: src/sro_store.sv
// Circular message store: one write port, one registered read port, logical indexing
// from a head base that advances on pop. Depends on sro_pkg for the entry type.
module sro_store import sro_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [IW-1:0] rd_idx_i,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_idx_i,
  input  entry_t        wr_entry_i,
  input  logic          advance_i,
  output entry_t        rd_entry_o
);

  localparam logic [IW:0] DepthVal = (IW+1)'(DEPTH);

  entry_t        mem [DEPTH];
  entry_t        rd_q;
  logic [IW-1:0] base_q, base_d;
  logic [IW-1:0] rd_phys, wr_phys;

  // Map a logical slot onto the ring
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [IW-1:0] idx);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= DepthVal) begin
      sum = sum - DepthVal;
    end
    return sum[IW-1:0];
  endfunction

  // Advance the head on a released beat
  assign base_d  = advance_i ? wrap_add(base_q, IW'(1)) : base_q;
  assign rd_phys = wrap_add(base_d, rd_idx_i);
  assign wr_phys = wrap_add(base_q, wr_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else begin
      base_q <= base_d;
    end
  end

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_phys] <= wr_entry_i;
    end
    rd_q <= mem[rd_phys];
  end

  assign rd_entry_o = rd_q;

endmodule

FILE: src/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer: sequencer, counters and output register.
// Depends on sro_pkg, sro_if, sro_cmp and sro_store.
//
//  channel | dir | handshake     | payload
//  in_i    | in  | valid/ready   | command, seq_number, payload_tag, last_processed
//  out_o   | out | valid/ready   | status, out_seq, out_tag, head_seq,
//          |     |               | contiguous_seq, occupancy
//
// One command at a time; in_i.ready is high only while the sequencer is idle.
// A receive scans down, shifts entries up where needed and walks the contiguity,
// all through one comparator and one store read port.
// Reset sets the buffer empty and the contiguous number to none at once.
// A result held in the output register stalls the sequencer only at its last step.
module sequence_reorder_buffer import sro_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  sro_in_if.sink    in_i,
  sro_out_if.source out_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic signed [NumW-1:0] contig_q, contig_d;
  logic [IW-1:0]          idx_q, idx_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [SeqW-1:0]        seq_q, seq_d;
  logic [TagW-1:0]        tag_q, tag_d;
  logic signed [NumW-1:0] lp_q, lp_d;
  status_e                status_q, status_d;
  logic [SeqW-1:0]        oseq_q, oseq_d;
  logic [TagW-1:0]        otag_q, otag_d;

  logic                   ov_q, ov_d;
  status_e                o_status_q, o_status_d;
  logic [SeqW-1:0]        o_seq_q, o_seq_d;
  logic [TagW-1:0]        o_tag_q, o_tag_d;
  logic signed [NumW-1:0] o_head_q, o_head_d;
  logic signed [NumW-1:0] o_contig_q, o_contig_d;
  logic [OccW-1:0]        o_occ_q, o_occ_d;

  logic                   wr_en, advance;
  logic [IW-1:0]          wr_idx;
  entry_t                 wr_entry, rd_entry;
  logic [SeqW-1:0]        cmp_a;
  logic signed [NumW:0]   cmp_b;
  logic                   cmp_gt, cmp_eq;
  logic                   in_ready;

  logic [CW-1:0]          idx_ext, cnt_m1, scan_pos;
  logic [IW-1:0]          last_idx;
  logic signed [NumW:0]   contig_ext, lp_ext;
  logic                   scan_done, scan_dup;
  logic [CW+OccW-1:0]     occ_wide;

  sro_store #(.DEPTH(DEPTH)) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_d),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_entry_i (wr_entry),
    .advance_i  (advance),
    .rd_entry_o (rd_entry)
  );

  sro_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .gt_o (cmp_gt),
    .eq_o (cmp_eq)
  );

  assign idx_ext    = CW'(idx_q);
  assign cnt_m1     = count_q - CW'(1);
  assign last_idx   = cnt_m1[IW-1:0];
  assign contig_ext = {contig_q[NumW-1], contig_q};
  assign lp_ext     = {lp_q[NumW-1], lp_q};

  // Scan ends at the first held number not above the new one, or at the head
  assign scan_done = !cmp_gt || (idx_q == '0);
  assign scan_pos  = cmp_gt ? '0 : idx_ext + CW'(1);
  assign scan_dup  = !cmp_gt && cmp_eq;

  // Route operands to the shared comparator
  always_comb begin
    cmp_a = (state_q == S_IDLE) ? in_i.seq_number : rd_entry.seq;
    unique case (state_q)
      S_IDLE:  cmp_b = contig_ext;
      S_SCAN:  cmp_b = {2'b00, seq_q};
      S_WALK:  cmp_b = contig_ext + (NumW+1)'(1);
      S_POP:   cmp_b = lp_ext + (NumW+1)'(1);
      default: cmp_b = '0;
    endcase
  end

  // Sequencer: next state, store control and result assembly
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    contig_d   = contig_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    seq_d      = seq_q;
    tag_d      = tag_q;
    lp_d       = lp_q;
    status_d   = status_q;
    oseq_d     = oseq_q;
    otag_d     = otag_q;
    ov_d       = ov_q && !out_o.ready;
    o_status_d = o_status_q;
    o_seq_d    = o_seq_q;
    o_tag_d    = o_tag_q;
    o_head_d   = o_head_q;
    o_contig_d = o_contig_q;
    o_occ_d    = o_occ_q;
    wr_en      = 1'b0;
    wr_idx     = idx_q + IW'(1);
    wr_entry   = rd_entry;
    advance    = 1'b0;
    in_ready   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          seq_d  = in_i.seq_number;
          tag_d  = in_i.payload_tag;
          lp_d   = in_i.last_processed;
          oseq_d = '0;
          otag_d = '0;
          idx_d  = '0;
          unique case (in_i.command)
            CMD_RECEIVE: begin
              if (!cmp_gt) begin
                // at or below the contiguous number: stale
                status_d = ST_DUPLICATE;
                state_d  = S_HEAD;
              end else if (count_q == '0) begin
                pos_d   = '0;
                state_d = S_INSERT;
              end else begin
                idx_d   = last_idx;
                state_d = S_SCAN;
              end
            end
            CMD_POP: begin
              if (count_q == '0) begin
                status_d = ST_NOT_READY;
                state_d  = S_HEAD;
              end else begin
                state_d = S_POP;
              end
            end
            CMD_CLEAR: begin
              contig_d = NoneNum;
              status_d = ST_CLEARED;
              state_d  = S_HEAD;
            end
            default: begin
              status_d = ST_NOT_READY;
              state_d  = S_HEAD;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (!scan_done) begin
          idx_d = idx_q - IW'(1);
        end else begin
          pos_d = scan_pos;
          if (scan_dup) begin
            status_d = ST_DUPLICATE;
            idx_d    = '0;
            state_d  = S_WALK;
          end else if (count_q == DepthCnt) begin
            status_d = ST_FULL;
            idx_d    = '0;
            state_d  = S_WALK;
          end else if (scan_pos == count_q) begin
            state_d = S_INSERT;
          end else begin
            idx_d   = last_idx;
            state_d = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // move one entry up a slot, tail first
        wr_en    = 1'b1;
        wr_idx   = idx_q + IW'(1);
        wr_entry = rd_entry;
        if (idx_ext == pos_q) begin
          state_d = S_INSERT;
        end else begin
          idx_d = idx_q - IW'(1);
        end
      end

      S_INSERT: begin
        wr_en    = 1'b1;
        wr_idx   = pos_q[IW-1:0];
        wr_entry = '{seq: seq_q, tag: tag_q};
        count_d  = count_q + CW'(1);
        status_d = ST_INSERTED;
        idx_d    = '0;
        state_d  = S_WALK_RD;
      end

      S_WALK_RD: begin
        idx_d   = '0;
        state_d = S_WALK;
      end

      S_WALK: begin
        // advance the contiguous number while no gap shows
        if (cmp_gt) begin
          idx_d   = '0;
          state_d = S_HEAD;
        end else begin
          contig_d = $signed({1'b0, rd_entry.seq});
          if (idx_ext + CW'(1) == count_q) begin
            idx_d   = '0;
            state_d = S_HEAD;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end

      S_POP: begin
        if (cmp_eq) begin
          oseq_d   = rd_entry.seq;
          otag_d   = rd_entry.tag;
          advance  = 1'b1;
          count_d  = cnt_m1;
          status_d = ST_RELEASED;
        end else begin
          status_d = ST_NOT_READY;
        end
        idx_d   = '0;
        state_d = S_HEAD;
      end

      S_HEAD: begin
        // head entry is on the read port; load the result when the slot frees
        idx_d = '0;
        if (!ov_q || out_o.ready) begin
          ov_d       = 1'b1;
          o_status_d = status_q;
          o_seq_d    = oseq_q;
          o_tag_d    = otag_q;
          o_head_d   = (count_q != '0) ? $signed({1'b0, rd_entry.seq}) : NoneNum;
          o_contig_d = contig_q;
          o_occ_d    = occ_wide[OccW-1:0];
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign occ_wide = {{OccW{1'b0}}, count_q};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      contig_q <= NoneNum;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      contig_q <= contig_d;
      ov_q     <= ov_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    seq_q      <= seq_d;
    tag_q      <= tag_d;
    lp_q       <= lp_d;
    status_q   <= status_d;
    oseq_q     <= oseq_d;
    otag_q     <= otag_d;
    o_status_q <= o_status_d;
    o_seq_q    <= o_seq_d;
    o_tag_q    <= o_tag_d;
    o_head_q   <= o_head_d;
    o_contig_q <= o_contig_d;
    o_occ_q    <= o_occ_d;
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = ov_q;
  assign out_o.status         = o_status_q;
  assign out_o.out_seq        = o_seq_q;
  assign out_o.out_tag        = o_tag_q;
  assign out_o.head_seq       = o_head_q;
  assign out_o.contiguous_seq = o_contig_q;
  assign out_o.occupancy      = o_occ_q;

endmodule

FILE: src/sro_checker.sv
// Port-level checks on the reorder buffer result channel, bound to the top level.
// Depends on sro_pkg for the status codes.
module sro_checker import sro_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [2:0]             status_i,
  input logic [SeqW-1:0]        out_seq_i,
  input logic [TagW-1:0]        out_tag_i,
  input logic signed [NumW-1:0] head_seq_i,
  input logic signed [NumW-1:0] contiguous_seq_i
);

  // A clear beat reports no contiguous number
  a_clear_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_CLEARED) |-> contiguous_seq_i == NoneNum)
    else $error("clear beat with contiguous number set");

  // Only a release carries a message
  a_idle_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_RELEASED) |-> (out_seq_i == '0) && (out_tag_i == '0))
    else $error("message fields set on a non-release beat");

  // The new head lies above the message just released
  a_release_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_RELEASED) |->
      (head_seq_i == NoneNum) || (head_seq_i > $signed({1'b0, out_seq_i})))
    else $error("head not above released message");

  // An insert leaves the buffer non-empty
  a_insert_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_INSERTED) |-> head_seq_i != NoneNum)
    else $error("insert beat shows an empty buffer");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(status_i) && $stable(head_seq_i) && $stable(out_seq_i))
    else $error("stalled result beat changed");

endmodule

bind sequence_reorder_buffer sro_checker u_sro_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .out_seq_i        (out_o.out_seq),
  .out_tag_i        (out_o.out_tag),
  .head_seq_i       (out_o.head_seq),
  .contiguous_seq_i (out_o.contiguous_seq)
);

FILE: verif/sro_order_checker.sv
// Result checker for the sequence reorder buffer: predicts every result beat from the
// accepted command beats and compares it with the beat the block delivers.
// Depends on sro_pkg and the channel interfaces in sro_if.
module sro_order_checker import sro_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sro_in_if                      in_mon,
  sro_out_if                     out_mon,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     held_o,
  output logic signed [NumW-1:0] head_o,
  output logic signed [NumW-1:0] contig_o
);

  typedef struct packed {
    status_e                status;
    logic [SeqW-1:0]        seq;
    logic [TagW-1:0]        tag;
    logic signed [NumW-1:0] head;
    logic signed [NumW-1:0] contig;
    logic [OccW-1:0]        occ;
  } outcome_t;

  // Shadow copy of the sorted message store
  logic [SeqW-1:0] held_seq [DEPTH];
  logic [TagW-1:0] held_tag [DEPTH];
  int unsigned     held_cnt   = 0;
  longint          contig_num = -1;

  outcome_t outcome_q [$];
  int       fails    = 0;
  int       waiting  = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;
  assign held_o       = held_cnt;
  assign contig_o     = contig_num[NumW-1:0];
  assign head_o       = (held_cnt > 0) ? $signed({1'b0, held_seq[0]}) : NoneNum;

  // Advance the contiguous number from the head while there is no gap
  function automatic void walk_contiguous();
    for (int unsigned i = 0; i < held_cnt; i++) begin
      if (longint'(held_seq[i]) > contig_num + 1) break;
      contig_num = longint'(held_seq[i]);
    end
  endfunction

  // Insert a message in order, or drop it as stale, duplicate or overflow
  function automatic status_e insert_message(logic [SeqW-1:0] seq, logic [TagW-1:0] tag);
    int unsigned pos;
    if (longint'(seq) <= contig_num) return ST_DUPLICATE;
    pos = held_cnt;
    while (pos > 0 && held_seq[pos-1] > seq) pos--;
    if (pos > 0 && held_seq[pos-1] == seq) begin
      walk_contiguous();
      return ST_DUPLICATE;
    end
    if (held_cnt >= DEPTH) begin
      walk_contiguous();
      return ST_FULL;
    end
    for (int unsigned i = held_cnt; i > pos; i--) begin
      held_seq[i] = held_seq[i-1];
      held_tag[i] = held_tag[i-1];
    end
    held_seq[pos] = seq;
    held_tag[pos] = tag;
    held_cnt      = held_cnt + 1;
    walk_contiguous();
    return ST_INSERTED;
  endfunction

  // Apply one command to the shadow state and build the result it causes
  function automatic outcome_t predict_outcome(logic [1:0] cmd, logic [SeqW-1:0] seq,
                                               logic [TagW-1:0] tag,
                                               logic signed [NumW-1:0] lp);
    outcome_t res;
    longint   lp_wide;
    lp_wide    = longint'(lp);
    res        = '0;
    res.status = ST_NOT_READY;
    case (cmd)
      CMD_RECEIVE: res.status = insert_message(seq, tag);
      CMD_POP: begin
        if (held_cnt > 0 && longint'(held_seq[0]) == lp_wide + 1) begin
          res.seq = held_seq[0];
          res.tag = held_tag[0];
          for (int unsigned i = 1; i < held_cnt; i++) begin
            held_seq[i-1] = held_seq[i];
            held_tag[i-1] = held_tag[i];
          end
          held_cnt   = held_cnt - 1;
          res.status = ST_RELEASED;
        end
      end
      CMD_CLEAR: begin
        contig_num = -1;
        res.status = ST_CLEARED;
      end
      default: ;
    endcase
    res.head   = (held_cnt > 0) ? $signed({1'b0, held_seq[0]}) : NoneNum;
    res.contig = contig_num[NumW-1:0];
    res.occ    = held_cnt[OccW-1:0];
    return res;
  endfunction

  // Check result beats against the oldest prediction, then queue new predictions
  always @(posedge clk_i) begin : monitor
    outcome_t want;
    outcome_t got;
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{status: status_e'(out_mon.status), seq: out_mon.out_seq,
                tag: out_mon.out_tag, head: out_mon.head_seq,
                contig: out_mon.contiguous_seq, occ: out_mon.occupancy};
        if (outcome_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result beat, actual %0d/%0h/%0h/%0d/%0d/%0d",
                   $time, got.status, got.seq, got.tag, got.head, got.contig, got.occ);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            fails++;
            // status/out_seq/out_tag/head/contiguous/occupancy
            $display({"%0t: result mismatch, expected %0d/%0h/%0h/%0d/%0d/%0d",
                      " actual %0d/%0h/%0h/%0d/%0d/%0d"},
                     $time, want.status, want.seq, want.tag, want.head, want.contig,
                     want.occ, got.status, got.seq, got.tag, got.head, got.contig,
                     got.occ);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        outcome_q.push_back(predict_outcome(in_mon.command, in_mon.seq_number,
                                            in_mon.payload_tag, in_mon.last_processed));
      end
      waiting = outcome_q.size();
    end
  end

endmodule

FILE: verif/tb_sequence_reorder_buffer.sv
// Testbench top for the sequence reorder buffer: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict.
// Depends on sro_pkg, sro_if, the block and sro_order_checker.
module tb_sequence_reorder_buffer import sro_pkg::*; ();

  localparam logic [1:0]  CmdUnused     = 2'd3;
  localparam int unsigned RandomBeats   = 1850;
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned SettleCycles  = 3 * DepthDefault + 30;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned MaxSession    = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sro_in_if  cmd_if ();
  sro_out_if res_if ();

  int                     fail_count;
  int                     pending;
  int                     held;
  logic signed [NumW-1:0] pred_head;
  logic signed [NumW-1:0] pred_contig;

  int unsigned burst_left  = 0;
  int unsigned beats_sent  = 0;
  int unsigned idle_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sequence_reorder_buffer #(
    .DEPTH (DepthDefault)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  sro_order_checker #(
    .DEPTH (DepthDefault)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .in_mon       (cmd_if),
    .out_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .held_o       (held),
    .head_o       (pred_head),
    .contig_o     (pred_contig)
  );

  // Drive one command beat from a falling edge, wait for it to be taken, then
  // idle between bursts; returns on the falling edge where the next beat may start
  task automatic offer_command(input logic [1:0] cmd, input logic [SeqW-1:0] seq,
                               input logic [TagW-1:0] tag,
                               input logic signed [NumW-1:0] lp, input bit aim_head);
    int unsigned gap;
    cmd_if.valid          <= 1'b1;
    cmd_if.command        <= cmd;
    cmd_if.seq_number     <= seq;
    cmd_if.payload_tag    <= tag;
    cmd_if.last_processed <= !aim_head ? lp : (held > 0) ? pred_head - 1 : NoneNum;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid          <= 1'b0;
      cmd_if.command        <= 2'($urandom);
      cmd_if.seq_number     <= SeqW'($urandom);
      cmd_if.payload_tag    <= TagW'($urandom);
      cmd_if.last_processed <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic offer_message(input logic [SeqW-1:0] seq, input logic [TagW-1:0] tag);
    offer_command(CMD_RECEIVE, seq, tag, $urandom, 1'b0);
  endtask

  // Release the predicted head so the store drains
  task automatic release_head();
    offer_command(CMD_POP, SeqW'($urandom), TagW'($urandom), NoneNum, 1'b1);
  endtask

  // Hold the idle counter at zero on any beat; fail the run on a hang
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Back-pressure the result channel in segments, with a long hold-off now and then
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned seg;
    seg = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      seg++;
      if (seg % 12 == 3) begin
        repeat (HoldOffCycles) begin
          @(negedge clk_i);
          res_if.ready <= 1'b0;
        end
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 150);
        repeat (span) begin
          @(negedge clk_i);
          case (mode)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= 1'($urandom_range(0, 1));
            2:       res_if.ready <= ($urandom_range(0, 7) == 0);
            default: res_if.ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    logic [SeqW-1:0]        base;
    logic [SeqW-1:0]        nums [MaxSession];
    logic [SeqW-1:0]        tmp;
    logic signed [NumW-1:0] stray;
    int unsigned            width;
    int unsigned            pop_pct;
    int unsigned            idx;
    int unsigned            pick;
    int unsigned            drain;
    int unsigned            j;
    int unsigned            k;

    cmd_if.valid          <= 1'b0;
    cmd_if.command        <= CMD_RECEIVE;
    cmd_if.seq_number     <= '0;
    cmd_if.payload_tag    <= '0;
    cmd_if.last_processed <= '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty pop, stale, duplicates, clear, unused command, lp extremes
    offer_command(CMD_POP, '0, '0, NoneNum, 1'b0);
    offer_message('0, '0);
    offer_message('0, 16'hFFFF);
    offer_message(31'd2, 16'hFFFF);
    offer_message(31'd2, 16'h1234);
    offer_message(31'd1, 16'hAAAA);
    offer_command(CMD_CLEAR, '1, '1, '1, 1'b0);
    offer_message(31'd1, 16'h5555);
    offer_command(CmdUnused, '1, '1, 32'sh7FFF_FFFF, 1'b0);
    offer_command(CMD_POP, '1, '1, 32'sh7FFF_FFFF, 1'b0);
    offer_command(CMD_POP, '0, '0, 32'sh8000_0000, 1'b0);
    offer_command(CMD_POP, '0, '0, NoneNum, 1'b0);
    // Fill the store from the top down, then overflow it with the largest number
    for (j = 16; j >= 3; j--) offer_message(SeqW'(j), TagW'($urandom));
    offer_message(31'h7FFF_FFFF, 16'h5555);

    // Random sessions: shuffled runs from the contiguous point, with noise
    while (beats_sent < RandomBeats) begin
      base = pred_contig[SeqW-1:0] + 1'b1;
      if ($urandom_range(0, 9) == 0) base = base + SeqW'($urandom_range(1, 4));
      width   = $urandom_range(1, MaxSession);
      pop_pct = $urandom_range(0, 45);
      for (j = 0; j < width; j++) nums[j] = base + SeqW'(j);
      for (j = width - 1; j > 0; j--) begin
        k       = $urandom_range(0, j);
        tmp     = nums[j];
        nums[j] = nums[k];
        nums[k] = tmp;
      end
      idx = 0;
      while (idx < width && beats_sent < RandomBeats) begin
        pick = $urandom_range(0, 99);
        if (pick < pop_pct) begin
          if ($urandom_range(0, 7) != 0) begin
            release_head();
          end else begin
            case ($urandom_range(0, 2))
              0:       stray = NoneNum;
              1:       stray = $urandom;
              default: stray = pred_head;
            endcase
            offer_command(CMD_POP, SeqW'($urandom), TagW'($urandom), stray, 1'b0);
          end
        end else if (pick < pop_pct + 4) begin
          offer_message(nums[$urandom_range(0, idx)], TagW'($urandom));
        end else if (pick < pop_pct + 7) begin
          offer_message((pred_contig >= 0) ? SeqW'($urandom_range(pred_contig, 0)) : '0,
                        TagW'($urandom));
        end else if (pick < pop_pct + 9) begin
          offer_message(SeqW'($urandom), TagW'($urandom));
        end else if (pick == 99) begin
          offer_command(CMD_CLEAR, SeqW'($urandom), TagW'($urandom), $urandom, 1'b0);
        end else if (pick == 98) begin
          offer_command(CmdUnused, SeqW'($urandom), TagW'($urandom), $urandom, 1'b0);
        end else begin
          offer_message(nums[idx], TagW'($urandom));
          idx++;
        end
        beats_sent++;
      end
      // Drain part of the store now and then
      if ($urandom_range(0, 3) == 0) begin
        drain = $urandom_range(0, held);
        repeat (drain) begin
          if (beats_sent < RandomBeats) begin
            release_head();
            beats_sent++;
          end
        end
      end
    end
    if (cmd_if.valid) cmd_if.valid <= 1'b0;

    // Wait for the last results, then let the block settle
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
